// ----- src/sha_pkg.sv -----
// sha_pkg: request and digest payload types, round constants, initial hash values
// and the SHA-256 sigma functions, shared by the sha modules other than sha_ram
// depends on nothing
package sha_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef logic [7:0][31:0] vars_t;

	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [2:0] MAX_COUNT  = 3'd4;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- src/sha256_message_digest.sv -----
// sha256_message_digest: SHA-256 over a byte stream given as 32-bit words
// depends on sha_pkg, sha_ram, sha_sched, sha_round
// one request is taken while idle; its bytes enter one per cycle, pausing while a full block is compressed
// a full block is compressed in 64 rounds, each split into phases because of the single read port
// of each schedule RAM copy, and a fold state then adds the result into the hash
// after the last request the padding bytes are pushed one at a time, then 8 digest words go out
// reset is asynchronous: control clears and the hash returns to the initial values
module sha256_message_digest import sha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_ready,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_ready,
	output dig_t dig
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_BYTES = 6'b000010,
		ST_PAD   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		PD_MARK = 3'b001,
		PD_ZERO = 3'b010,
		PD_LEN  = 3'b100
	} pad_t;

	state_t      st_q, resume_q, gen_st;
	pad_t        pad_q, gen_pad;
	logic [1:0]  ph_q;
	logic [5:0]  rnd_q;
	logic [5:0]  bytes_q;
	logic [31:0] partial_q;
	logic [63:0] bits_q;
	vars_t       hash_q, vars_q, vars_n;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        fin_q;
	logic [1:0]  bidx_q;
	logic [2:0]  lidx_q;
	logic [2:0]  oidx_q;
	logic [31:0] w2_q, w15_q, wsch_q;

	logic        push_en;
	logic [7:0]  push_b;
	logic [31:0] word_full;
	logic        we;
	logic [3:0]  waddr, ra0, ra1;
	logic [31:0] wdata, rd0, rd1, wexp;
	logic        late_rnd;
	logic [63:0] len_sh;
	logic [31:0] byte_sh;

	assign late_rnd  = rnd_q[5] | rnd_q[4];
	assign byte_sh   = word_q >> (5'd24 - {bidx_q, 3'b000});
	assign len_sh    = bits_q >> (6'd56 - {lidx_q, 3'b000});
	assign word_full = partial_q | ({24'd0, push_b} << (5'd24 - {bytes_q[1:0], 3'b000}));

	always_comb begin
		push_en = 1'b0;
		push_b  = 8'd0;
		gen_st  = st_q;
		gen_pad = pad_q;
		case (st_q)
			ST_BYTES: begin
				push_en = 1'b1;
				push_b  = byte_sh[7:0];
				gen_pad = PD_MARK;
				if (({1'b0, bidx_q} + 3'd1) < cnt_q) begin
					gen_st = ST_BYTES;
				end else if (fin_q) begin
					gen_st = ST_PAD;
				end else begin
					gen_st = ST_IDLE;
				end
			end
			ST_PAD: begin
				case (pad_q)
					PD_MARK: begin
						push_en = 1'b1;
						push_b  = PAD_MARK;
						gen_pad = PD_ZERO;
					end
					PD_ZERO: begin
						if (bytes_q == LENGTH_POS) begin
							gen_pad = PD_LEN;
						end else begin
							push_en = 1'b1;
						end
					end
					PD_LEN: begin
						push_en = 1'b1;
						push_b  = len_sh[7:0];
						if (lidx_q == 3'd7) begin
							gen_st = ST_OUT;
						end
					end
					default: gen_pad = PD_MARK;
				endcase
			end
			default: ;
		endcase
	end

	// schedule reads: phase 0 fetches t-2 and t-15, phase 1 fetches t-7 and t
	always_comb begin
		if (ph_q == 2'd0) begin
			ra0 = 4'(rnd_q - 6'd2);
			ra1 = 4'(rnd_q - 6'd15);
		end else begin
			ra0 = 4'(rnd_q - 6'd7);
			ra1 = rnd_q[3:0];
		end
	end

	always_comb begin
		if (st_q == ST_ROUND) begin
			we    = (ph_q == 2'd2) && late_rnd;
			waddr = rnd_q[3:0];
			wdata = wexp;
		end else begin
			we    = push_en && (bytes_q[1:0] == 2'd3);
			waddr = bytes_q[5:2];
			wdata = word_full;
		end
	end

	sha_ram #(.WIDTH(32), .DEPTH(16)) u_win0 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra0), .rdata(rd0)
	);

	sha_ram #(.WIDTH(32), .DEPTH(16)) u_win1 (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra1), .rdata(rd1)
	);

	sha_sched u_sched (
		.w2(w2_q), .w7(rd0), .w15(w15_q), .w16(rd1), .w(wexp)
	);

	sha_round u_round (
		.v(vars_q), .k(ROUND_K[rnd_q]), .w(wsch_q), .nv(vars_n)
	);

	assign msg_ready       = (st_q == ST_IDLE);
	assign dig_valid       = (st_q == ST_OUT);
	assign dig.digest_word = hash_q[oidx_q];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			resume_q  <= ST_IDLE;
			pad_q     <= PD_MARK;
			ph_q      <= 2'd0;
			rnd_q     <= 6'd0;
			bytes_q   <= 6'd0;
			partial_q <= 32'd0;
			bits_q    <= 64'd0;
			cnt_q     <= 3'd0;
			fin_q     <= 1'b0;
			bidx_q    <= 2'd0;
			lidx_q    <= 3'd0;
			oidx_q    <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= INIT_H[i];
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (msg_valid) begin
						word_q <= msg.data_word;
						cnt_q  <= (msg.byte_count > MAX_COUNT) ? MAX_COUNT : msg.byte_count;
						fin_q  <= msg.last;
						bidx_q <= 2'd0;
						lidx_q <= 3'd0;
						pad_q  <= PD_MARK;
						if (msg.byte_count != 3'd0) begin
							st_q <= ST_BYTES;
						end else if (msg.last) begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_BYTES, ST_PAD: begin
					pad_q <= gen_pad;
					if (push_en) begin
						partial_q <= (bytes_q[1:0] == 2'd3) ? 32'd0 : word_full;
						bytes_q   <= bytes_q + 6'd1;
						if (st_q == ST_BYTES) begin
							bidx_q <= bidx_q + 2'd1;
							bits_q <= bits_q + 64'd8;
						end else if (pad_q == PD_LEN) begin
							lidx_q <= lidx_q + 3'd1;
						end
					end
					if (push_en && (bytes_q == LAST_BYTE)) begin
						st_q     <= ST_ROUND;
						resume_q <= gen_st;
						vars_q   <= hash_q;
						ph_q     <= 2'd0;
						rnd_q    <= 6'd0;
					end else begin
						st_q <= gen_st;
					end
				end
				ST_ROUND: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						w2_q  <= rd0;
						w15_q <= rd1;
					end
					if (ph_q == 2'd2) begin
						wsch_q <= late_rnd ? wexp : rd1;
					end
					if (ph_q == 2'd3) begin
						vars_q <= vars_n;
						rnd_q  <= rnd_q + 6'd1;
						if (rnd_q == LAST_BYTE) begin
							st_q <= ST_FOLD;
						end
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + vars_q[i];
					end
					st_q <= resume_q;
				end
				ST_OUT: begin
					if (dig_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= INIT_H[i];
							end
							bits_q    <= 64'd0;
							partial_q <= 32'd0;
							bytes_q   <= 6'd0;
							st_q      <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/sha_ram.sv -----
// sha_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/sha_sched.sv -----
// sha_sched: message schedule expansion of one word from four window words
// depends on sha_pkg
module sha_sched import sha_pkg::*; (
	input  logic [31:0] w2,
	input  logic [31:0] w7,
	input  logic [31:0] w15,
	input  logic [31:0] w16,
	output logic [31:0] w
);

	assign w = small_s1(w2) + w7 + small_s0(w15) + w16;

endmodule

// ----- src/sha_round.sv -----
// sha_round: one SHA-256 compression round over the working variables a..h
// depends on sha_pkg
module sha_round import sha_pkg::*; (
	input  vars_t       v,
	input  logic [31:0] k,
	input  logic [31:0] w,
	output vars_t       nv
);

	logic [31:0] t1;
	logic [31:0] t2;

	assign t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
	assign t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

	always_comb begin
		nv[7] = v[6];
		nv[6] = v[5];
		nv[5] = v[4];
		nv[4] = v[3] + t1;
		nv[3] = v[2];
		nv[2] = v[1];
		nv[1] = v[0];
		nv[0] = t1 + t2;
	end

endmodule

// ----- bench/sha256_digest_track.sv -----
// sha256_digest_track: scoreboard class that hashes accepted requests and checks digest words
// depends on sha_pkg for the msg_t and dig_t payload types
package sha256_digest_track;
	import sha_pkg::*;

	class digest_scoreboard;
		logic [31:0] hash_h [8];
		logic [31:0] block_w [16];
		logic [63:0] bit_len;
		logic [31:0] word_acc;
		logic [5:0]  block_fill;
		dig_t        pending_digest [$];
		int          mismatch_count;

		function new();
			mismatch_count = 0;
			restart();
		endfunction

		function void restart();
			hash_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			bit_len = '0;
			word_acc = '0;
			block_fill = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int r);
			return (x >> r) | (x << (32 - r));
		endfunction

		function void compress();
			logic [31:0] k [64];
			logic [31:0] v [8];
			logic [31:0] w [16];
			logic [31:0] s0, s1, t1, t2;
			k = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
			v = hash_h;
			w = block_w;
			for (int t = 0; t < 64; t++) begin
				if (t >= 16) begin
					s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
					s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
					w[t%16] = s1 + w[(t-7)%16] + s0 + w[t%16];
				end
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w[t%16];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hash_h[i] += v[i];
		endfunction

		function void add_byte(logic [7:0] b);
			word_acc |= 32'(b) << (24 - 8 * block_fill[1:0]);
			if (block_fill[1:0] == 2'd3) begin
				block_w[block_fill[5:2]] = word_acc;
				word_acc = '0;
			end
			block_fill++;
			if (block_fill == 6'd0)
				compress();
		endfunction

		function void note_request(msg_t m);
			int n;
			logic [63:0] len;
			dig_t d;
			n = (m.byte_count > 3'd4) ? 4 : m.byte_count;
			for (int i = 0; i < n; i++) begin
				add_byte(m.data_word[31 - 8 * i -: 8]);
				bit_len += 64'd8;
			end
			if (!m.last)
				return;
			len = bit_len;
			add_byte(8'h80);
			while (block_fill != 6'd56)
				add_byte(8'h00);
			for (int i = 0; i < 8; i++)
				add_byte(len[63 - 8 * i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hash_h[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				pending_digest.push_back(d);
			end
			restart();
		endfunction

		function void check_digest(dig_t got);
			dig_t want;
			if (pending_digest.size() == 0) begin
				$display("%0t: unexpected digest word, actual %h", $time, got);
				mismatch_count++;
				return;
			end
			want = pending_digest.pop_front();
			if (got.digest_word !== want.digest_word) begin
				$display("%0t: digest_word expected %h actual %h", $time,
					want.digest_word, got.digest_word);
				mismatch_count++;
			end
			if (got.word_index !== want.word_index) begin
				$display("%0t: word_index expected %0d actual %0d", $time,
					want.word_index, got.word_index);
				mismatch_count++;
			end
			if (got.last_word !== want.last_word) begin
				$display("%0t: last_word expected %b actual %b", $time,
					want.last_word, got.last_word);
				mismatch_count++;
			end
		endfunction
	endclass
endpackage

// ----- bench/tb.sv -----
// tb: drives sha256_message_digest with messages of random length and checks every digest word
// depends on sha_pkg, sha256_digest_track and the RTL under src
module tb;
	import sha_pkg::*;
	import sha256_digest_track::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic msg_valid;
	logic msg_ready;
	msg_t msg;
	logic dig_valid;
	logic dig_ready;
	dig_t dig;

	digest_scoreboard sb;
	int unsigned cycle_count;
	int unsigned request_count;
	bit long_hold;

	sha256_message_digest i_dut (
		.clk(clk), .arst_n(arst_n),
		.msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
		.dig_valid(dig_valid), .dig_ready(dig_ready), .dig(dig)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(logic [31:0] w, logic [2:0] n, logic l);
		int g;
		g = gap_len();
		if (g != 0) begin
			msg_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= '{data_word: w, byte_count: n, last: l};
		do
			@(posedge clk);
		while (!msg_ready);
		sb.note_request(msg);
		request_count++;
	endtask

	task automatic send_message(int nwords, logic [2:0] tail);
		for (int i = 0; i < nwords; i++)
			send_request($urandom, 3'($urandom_range(1, 7)), 1'b0);
		send_request($urandom, tail, 1'b1);
	endtask

	task automatic drain();
		msg_valid <= 1'b0;
		while (sb.pending_digest.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (dig_valid && dig_ready)
			sb.check_digest(dig);
	end

	initial begin
		int r;
		dig_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				dig_ready <= 1'b0;
				repeat (4000) @(posedge clk);
				long_hold = 1'b0;
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				dig_ready <= 1'b1;
			else if (r < 95)
				dig_ready <= 1'b0;
			else begin
				dig_ready <= 1'b0;
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 2000000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		request_count = 0;
		long_hold = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, "abc", all-ones bytes, all-zero bytes followed by deadbeef bytes
		send_request(32'h0, 3'd0, 1'b1);
		send_request(32'h61626300, 3'd3, 1'b1);
		send_request(32'hffffffff, 3'd4, 1'b0);
		send_request(32'hffffffff, 3'd7, 1'b1);
		send_request(32'h00000000, 3'd4, 1'b0);
		send_request(32'h12345678, 3'd0, 1'b0);
		send_request(32'h00000000, 3'd5, 1'b0);
		send_request(32'hdeadbeef, 3'd6, 1'b0);
		send_request(32'hdeadbeef, 3'd0, 1'b1);
		// 55 bytes: the pad mark and the length still fit in the same block
		for (int i = 0; i < 13; i++)
			send_request($urandom, 3'd4, 1'b0);
		send_request($urandom, 3'd3, 1'b1);
		drain();

		// receiver stalls long while a multi-block message keeps arriving
		long_hold = 1'b1;
		send_message(40, 3'd2);
		send_message(2, 3'd1);
		drain();

		while (request_count < 216) begin
			r_msg: begin
				int nw;
				nw = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 34)
					: $urandom_range(0, 8);
				send_message(nw, 3'($urandom_range(0, 7)));
			end
		end
		drain();
		repeat (300) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending_digest.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- sim.f -----
src/sha_pkg.sv
src/sha_ram.sv
src/sha_sched.sv
src/sha_round.sv
src/sha256_message_digest.sv
bench/sha256_digest_track.sv
bench/tb.sv
